@@ hw/rtl/b64x_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package b64x_pkg;

   // Configuration register indexes
   localparam logic [7:0] CSR_KEY_BYTE        = 8'd0;
   localparam logic [7:0] CSR_ALPHABET_SELECT = 8'd1;

   // Register reset values
   localparam logic [7:0] KEY_BYTE_RESET = 8'd11;
   localparam logic       ALPHABET_RESET = 1'b0;

   // Character codes
   localparam logic [7:0] PAD_CHAR    = 8'h3D;
   localparam logic [7:0] UPPER_FIRST = 8'h41;
   localparam logic [7:0] UPPER_LAST  = 8'h5A;
   localparam logic [7:0] LOWER_FIRST = 8'h61;
   localparam logic [7:0] LOWER_LAST  = 8'h7A;
   localparam logic [7:0] DIGIT_FIRST = 8'h30;
   localparam logic [7:0] DIGIT_LAST  = 8'h39;
   localparam logic [7:0] STD_PLUS    = 8'h2B;
   localparam logic [7:0] STD_SLASH   = 8'h2F;
   localparam logic [7:0] URL_MINUS   = 8'h2D;
   localparam logic [7:0] URL_UNDER   = 8'h5F;

   // Decoder state carried between characters
   typedef struct packed {
      logic [5:0] pend_bits;
      logic [2:0] pend_count;
      logic       pad_seen;
   } state_type;

   // One result item
   typedef struct packed {
      logic       byte_valid;
      logic [7:0] data_byte;
      logic       string_done;
   } result_type;

   // Table lookup result for one character
   typedef struct packed {
      logic       hit;
      logic [5:0] value;
   } sextet_type;

   // Map a character to its six-bit value in the selected alphabet
   function automatic sextet_type sextet_of(input logic [7:0] ch, input logic url_safe);
      sextet_type s;
      logic [7:0] diff;
      s    = '0;
      diff = '0;
      if (ch >= UPPER_FIRST && ch <= UPPER_LAST) begin
         diff = ch - UPPER_FIRST;
         s.hit = 1'b1;
         s.value = diff[5:0];
      end else if (ch >= LOWER_FIRST && ch <= LOWER_LAST) begin
         diff = ch - LOWER_FIRST + 8'd26;
         s.hit = 1'b1;
         s.value = diff[5:0];
      end else if (ch >= DIGIT_FIRST && ch <= DIGIT_LAST) begin
         diff = ch - DIGIT_FIRST + 8'd52;
         s.hit = 1'b1;
         s.value = diff[5:0];
      end else if (url_safe) begin
         if (ch == URL_MINUS) begin
            s.hit = 1'b1;
            s.value = 6'd62;
         end else if (ch == URL_UNDER) begin
            s.hit = 1'b1;
            s.value = 6'd63;
         end
      end else begin
         if (ch == STD_PLUS) begin
            s.hit = 1'b1;
            s.value = 6'd62;
         end else if (ch == STD_SLASH) begin
            s.hit = 1'b1;
            s.value = 6'd63;
         end
      end
      return s;
   endfunction

endpackage

`default_nettype wire

@@ hw/rtl/b64x_step.sv @@
`timescale 1ns / 1ps
`default_nettype none

module b64x_step (
   input  wire b64x_pkg::state_type  state_i,
   input  wire logic [7:0]           char_code,
   input  wire logic                 end_of_text,
   input  wire logic [7:0]           key_byte,
   input  wire logic                 alphabet_select,
   output b64x_pkg::state_type       state_o,
   output b64x_pkg::result_type      result_o
);

   b64x_pkg::sextet_type sx;
   logic [11:0] acc;
   logic [3:0]  total;
   logic [3:0]  rest_wide;
   logic [2:0]  rest;
   logic [11:0] shifted;
   logic [11:0] keep_mask;
   logic [11:0] kept;

   // Look up the character and line up the new bits behind the pending ones
   always_comb begin
      sx        = b64x_pkg::sextet_of(char_code, alphabet_select);
      acc       = {state_i.pend_bits, sx.value};
      total     = {1'b0, state_i.pend_count} + 4'd6;
      rest_wide = total - 4'd8;
      rest      = rest_wide[2:0];
      shifted   = acc >> rest;
      keep_mask = (12'd1 << rest) - 12'd1;
      kept      = acc & keep_mask;
   end

   // Advance the state and form the result
   always_comb begin
      state_o              = state_i;
      result_o             = '0;
      result_o.string_done = end_of_text;
      if (!state_i.pad_seen) begin
         if (char_code == b64x_pkg::PAD_CHAR) begin
            state_o.pad_seen = 1'b1;
         end else if (sx.hit) begin
            if (total >= 4'd8) begin
               result_o.byte_valid = 1'b1;
               result_o.data_byte  = shifted[7:0] ^ key_byte;
               state_o.pend_bits   = kept[5:0];
               state_o.pend_count  = rest;
            end else begin
               state_o.pend_bits  = acc[5:0];
               state_o.pend_count = total[2:0];
            end
         end
      end
      // Clear everything after the last character of a string
      if (end_of_text) begin
         state_o = '0;
      end
   end

endmodule

`default_nettype wire

@@ hw/rtl/base64_decode_xor_bytes_unit.sv @@
// A req_ transfer reaches rsp_tvalid through the input register, then the result register.
// Throughput: one character per cycle while rsp_tready does not stall the result register.
// A stalled rsp_ side holds one result while one more character waits in the input register.
// Reset (synchronous, active high) empties both registers, clears the pending bits and the
// pad flag, and returns key_byte to 11 and alphabet_select to the standard alphabet.
`timescale 1ns / 1ps
`default_nettype none

module base64_decode_xor_bytes_unit (
   input  wire logic       clock,
   input  wire logic       reset,
   // request stream
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [7:0] req_tdata,   // [7:0] char_code
   input  wire logic       req_tlast,   // end_of_text
   // response stream
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output logic [7:0]      rsp_tdata,   // [7:0] data_byte
   output logic            rsp_tuser,   // [0] byte_valid
   output logic            rsp_tlast,   // string_done
   // configuration writes
   input  wire logic       csr_valid,
   output logic            csr_ready,
   input  wire logic [7:0] csr_index,
   input  wire logic [7:0] csr_data
);

   logic                 in_valid_ff, in_valid_in;
   logic [7:0]           in_char_ff,  in_char_in;
   logic                 in_last_ff,  in_last_in;
   logic                 out_valid_ff, out_valid_in;
   b64x_pkg::result_type out_result_ff, out_result_in;
   b64x_pkg::state_type  state_ff, state_in;
   logic [7:0]           key_ff, key_in;
   logic                 alpha_ff, alpha_in;

   b64x_pkg::state_type  step_state;
   b64x_pkg::result_type step_result;
   logic                 advance;
   logic                 req_xfer;

   b64x_step u_step (
      .state_i         (state_ff),
      .char_code       (in_char_ff),
      .end_of_text     (in_last_ff),
      .key_byte        (key_ff),
      .alphabet_select (alpha_ff),
      .state_o         (step_state),
      .result_o        (step_result)
   );

   // Move a character into the result register when that register is free
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_xfer   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   // Input register
   always_comb begin
      in_valid_in = in_valid_ff;
      in_char_in  = in_char_ff;
      in_last_in  = in_last_ff;
      if (req_xfer) begin
         in_valid_in = 1'b1;
         in_char_in  = req_tdata;
         in_last_in  = req_tlast;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   // Result register and decoder state
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_result_in = out_result_ff;
      state_in      = state_ff;
      if (advance) begin
         out_valid_in  = 1'b1;
         out_result_in = step_result;
         state_in      = step_state;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   // Configuration registers; indexes beyond the list are dropped
   always_comb begin
      key_in   = key_ff;
      alpha_in = alpha_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            b64x_pkg::CSR_KEY_BYTE:        key_in   = csr_data;
            b64x_pkg::CSR_ALPHABET_SELECT: alpha_in = csr_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '0;
         key_ff       <= b64x_pkg::KEY_BYTE_RESET;
         alpha_ff     <= b64x_pkg::ALPHABET_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         state_ff     <= state_in;
         key_ff       <= key_in;
         alpha_ff     <= alpha_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      in_char_ff    <= in_char_in;
      in_last_ff    <= in_last_in;
      out_result_ff <= out_result_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_result_ff.data_byte;
   assign rsp_tuser  = out_result_ff.byte_valid;
   assign rsp_tlast  = out_result_ff.string_done;

endmodule

`default_nettype wire

@@ hw/rtl/b64x_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

module b64x_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_tvalid,
   input wire logic       req_tready,
   input wire logic       rsp_tvalid,
   input wire logic       rsp_tready,
   input wire logic [7:0] rsp_tdata,
   input wire logic       rsp_tuser,
   input wire logic       rsp_tlast
);

   // A result without a decoded byte carries a zero byte
   a_zero_when_no_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata == 8'd0)
      else $error("rsp_tdata nonzero on a result without a byte");

   // Reset empties the result register
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp_tvalid high right after reset");

   // Every request transfer is followed by rsp_tvalid, through the input and result registers
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |-> ##2 rsp_tvalid)
      else $error("no result two cycles after a request transfer");

   // A stalled result holds
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled result changed");

endmodule

bind base64_decode_xor_bytes_unit b64x_checker u_b64x_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire
